@@ hdl/scl_pkg.sv @@
// Shared types and constants for the sorted key list core.
// No dependencies.
`default_nettype none
package scl_pkg;
	localparam int KEY_W     = 8;
	localparam int OPCODE_W  = 2;
	localparam int POS_W     = 4;
	localparam int CNT_OUT_W = 5;

	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

	typedef logic signed [KEY_W-1:0] key_t;

	// broadcast from the control logic to every cell
	typedef struct packed {
		logic ins;
		key_t key;
	} cell_ctl_t;
endpackage
`default_nettype wire

@@ hdl/scl_if.sv @@
// Valid/ready channel interfaces for the request and response beats.
// Depends on scl_pkg.
`default_nettype none
interface scl_req_if;
	import scl_pkg::*;
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	key_t                key_value;
	logic                from_end;
	modport source (output valid, opcode, key_value, from_end, input ready);
	modport sink (input valid, opcode, key_value, from_end, output ready);
endinterface

interface scl_rsp_if;
	import scl_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 ok;
	logic                 found;
	logic [POS_W-1:0]     position;
	logic [CNT_OUT_W-1:0] entry_count;
	modport source (output valid, ok, found, position, entry_count, input ready);
	modport sink (input valid, ok, found, position, entry_count, output ready);
endinterface
`default_nettype wire

@@ hdl/scl_cell.sv @@
// One slot of the sorted chain: holds a key, compares it against the
// broadcast key and takes the new key or its lower neighbor's key on insert.
// Depends on scl_pkg.
`default_nettype none
module scl_cell (
	input  wire              clk,
	input  scl_pkg::cell_ctl_t ctl,
	input  wire              occ,
	input  wire              prev_keep,
	input  scl_pkg::key_t    prev_key,
	output logic             keep,
	output logic             eq,
	output scl_pkg::key_t    key
);
	import scl_pkg::*;

	key_t key_q;

	assign keep = occ && (key_q <= ctl.key);
	assign eq   = occ && (key_q == ctl.key);
	assign key  = key_q;

	// keep, load the new key at the boundary, or shift up from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			key_q <= prev_keep ? ctl.key : prev_key;
		end
	end
endmodule
`default_nettype wire

@@ hdl/sorted_char_list_insert_search_core.sv @@
// Sorted store of signed 8-bit keys held in a chain of compare-and-shift cells.
// One request beat is taken per cycle while the output register is empty or being
// drained; its response appears in the output register the cycle after. Insert,
// search and clear each complete in the cycle the request is taken, with all cells
// comparing against the broadcast key in parallel; a search position comes from the
// edge of the contiguous run of matching cells.
// Depends on scl_pkg, scl_if and scl_cell.
`default_nettype none
module sorted_char_list_insert_search_core #(
	parameter int STORE_DEPTH = 16
) (
	input wire      clk,
	input wire      arst_n,
	scl_req_if.sink   req,
	scl_rsp_if.source rsp
);
	import scl_pkg::*;

	localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_nxt;
	logic                 rsp_vld_q;
	logic                 ok_q;
	logic                 found_q;
	logic [POS_W-1:0]     pos_q;
	logic [CNT_OUT_W-1:0] cnt_q;

	logic                   acc;
	logic                   full;
	cell_ctl_t              ctl;
	logic [STORE_DEPTH-1:0] occ;
	logic [STORE_DEPTH-1:0] keep;
	logic [STORE_DEPTH-1:0] eq;
	logic [STORE_DEPTH-1:0] first_hit;
	logic [STORE_DEPTH-1:0] last_hit;
	logic [STORE_DEPTH-1:0] sel_hit;
	key_t                   keys [STORE_DEPTH];
	logic [IDX_W-1:0]       hit_idx;
	logic                   ok_d;
	logic                   found_d;

	assign req.ready = !rsp_vld_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(STORE_DEPTH));
	assign ctl.ins   = acc && (req.opcode == OP_INSERT) && !full;
	assign ctl.key   = req.key_value;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			scl_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occ      (occ[i]),
				.prev_keep(1'b1),
				.prev_key (ctl.key),
				.keep     (keep[i]),
				.eq       (eq[i]),
				.key      (keys[i])
			);
			assign first_hit[i] = eq[i];
		end else begin : g_body
			scl_cell u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.occ      (occ[i]),
				.prev_keep(keep[i-1]),
				.prev_key (keys[i-1]),
				.keep     (keep[i]),
				.eq       (eq[i]),
				.key      (keys[i])
			);
			assign first_hit[i] = eq[i] && !eq[i-1];
		end
		if (i == STORE_DEPTH - 1) begin : g_tail
			assign last_hit[i] = eq[i];
		end else begin : g_mid
			assign last_hit[i] = eq[i] && !eq[i+1];
		end
	end

	assign sel_hit = req.from_end ? last_hit : first_hit;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			hit_idx = hit_idx | (sel_hit[i] ? IDX_W'(i) : '0);
		end
	end

	always_comb begin
		ok_d      = 1'b0;
		found_d   = 1'b0;
		count_nxt = count_q;
		unique case (req.opcode)
			OP_INSERT: begin
				ok_d = !full;
				if (!full) begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_SEARCH: begin
				found_d = |sel_hit;
			end
			OP_CLEAR: begin
				ok_d      = 1'b1;
				count_nxt = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q   <= count_nxt;
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// hold the response beat until it drains
	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q    <= ok_d;
			found_q <= found_d;
			pos_q   <= found_d ? POS_W'(hit_idx) : '0;
			cnt_q   <= CNT_OUT_W'(count_nxt);
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.ok          = ok_q;
	assign rsp.found       = found_q;
	assign rsp.position    = pos_q;
	assign rsp.entry_count = cnt_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STORE_DEPTH))
		else $error("key count above store depth");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (req.opcode == OP_CLEAR) |=> rsp.valid && (count_q == '0) && rsp.ok)
		else $error("clear did not empty the store");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (req.opcode == OP_INSERT) && full |=> !rsp.ok && $stable(count_q))
		else $error("insert into a full store changed state");

	a_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.found && rsp.ok))
		else $error("found and ok both set");
endmodule
`default_nettype wire

@@ tb/sv/sorted_char_list_insert_search_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench for sorted_char_list_insert_search_core: directed table, then random beats
// under three idle/stall profiles; checks use a sorted-store predictor or a fixed row.
// Depends on scl_pkg, scl_if and the core RTL.
module sorted_char_list_insert_search_core_tb;
	import scl_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int RANDOM_PER_PHASE = 625;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                 ok;
		logic                 found;
		logic [POS_W-1:0]     position;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_beat_t;

	typedef struct {
		logic [OPCODE_W-1:0] op;
		int                  key;
		logic                fe;
		bit                  fixed;
		rsp_beat_t           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scl_req_if req_ch ();
	scl_rsp_if rsp_ch ();

	key_t      held_keys [STORE_DEPTH];
	int        held_count;
	rsp_beat_t pending_rsp [$];
	int        fail_count;
	int        quiet_cycles;
	int        src_idle_pct;
	int        snk_stall_pct;

	stim_row_t dir_rows [26] = '{
		'{OP_SEARCH, 0,    1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 5'd0}},
		'{OP_INSERT, 127,  1'b0, 1'b1, '{1'b1, 1'b0, 4'd0, 5'd1}},
		'{OP_INSERT, -128, 1'b1, 1'b1, '{1'b1, 1'b0, 4'd0, 5'd2}},
		'{OP_INSERT, 0,    1'b0, 1'b0, '0},
		'{OP_INSERT, 0,    1'b1, 1'b0, '0},
		'{OP_INSERT, 0,    1'b0, 1'b0, '0},
		'{OP_INSERT, -1,   1'b0, 1'b0, '0},
		'{OP_INSERT, 1,    1'b0, 1'b0, '0},
		'{OP_INSERT, 64,   1'b0, 1'b0, '0},
		'{OP_INSERT, -64,  1'b0, 1'b0, '0},
		'{OP_INSERT, 100,  1'b0, 1'b0, '0},
		'{OP_INSERT, -100, 1'b0, 1'b0, '0},
		'{OP_INSERT, 32,   1'b0, 1'b0, '0},
		'{OP_INSERT, -32,  1'b0, 1'b0, '0},
		'{OP_INSERT, 126,  1'b0, 1'b0, '0},
		'{OP_INSERT, -127, 1'b0, 1'b0, '0},
		'{OP_INSERT, 5,    1'b0, 1'b0, '0},
		'{OP_INSERT, 9,    1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 5'd16}},
		'{OP_SEARCH, 0,    1'b0, 1'b0, '0},
		'{OP_SEARCH, 0,    1'b1, 1'b0, '0},
		'{OP_SEARCH, -128, 1'b1, 1'b0, '0},
		'{OP_SEARCH, 127,  1'b0, 1'b0, '0},
		'{OP_SEARCH, 7,    1'b1, 1'b0, '0},
		'{OP_UNUSED, -1,   1'b1, 1'b0, '0},
		'{OP_CLEAR,  0,    1'b0, 1'b1, '{1'b1, 1'b0, 4'd0, 5'd0}},
		'{OP_SEARCH, 127,  1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 5'd0}}
	};

	sorted_char_list_insert_search_core #(.STORE_DEPTH(STORE_DEPTH)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	function automatic rsp_beat_t store_step(input logic [OPCODE_W-1:0] op, input key_t k,
			input logic fe);
		rsp_beat_t r;
		int        slot;
		int        i;
		r = '0;
		case (op)
			OP_INSERT: begin
				if (held_count < STORE_DEPTH) begin
					slot = 0;
					while (slot < held_count && held_keys[slot] <= k)
						slot++;
					for (i = held_count; i > slot; i--)
						held_keys[i] = held_keys[i-1];
					held_keys[slot] = k;
					held_count++;
					r.ok = 1'b1;
				end
			end
			OP_SEARCH: begin
				if (!fe) begin
					for (i = 0; i < held_count && !r.found; i++)
						if (held_keys[i] == k) begin
							r.found = 1'b1;
							r.position = i[POS_W-1:0];
						end
				end else begin
					for (i = held_count - 1; i >= 0 && !r.found; i--)
						if (held_keys[i] == k) begin
							r.found = 1'b1;
							r.position = i[POS_W-1:0];
						end
				end
			end
			OP_CLEAR: begin
				held_count = 0;
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.entry_count = held_count[CNT_OUT_W-1:0];
		return r;
	endfunction

	// enter and leave at a falling edge
	task automatic send_beat(input logic [OPCODE_W-1:0] op, input key_t k, input logic fe,
			input bit fixed, input rsp_beat_t want);
		rsp_beat_t model_out;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.opcode    <= op;
		req_ch.key_value <= k;
		req_ch.from_end  <= fe;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		model_out = store_step(op, k, fe);
		pending_rsp.push_back(fixed ? want : model_out);
		@(negedge clk);
	endtask

	task automatic send_random();
		int                  pick;
		key_t                k;
		logic [OPCODE_W-1:0] op;
		pick = $urandom_range(99);
		if (pick < 3)
			op = OP_CLEAR;
		else if (pick < 5)
			op = OP_UNUSED;
		else if (pick < 50)
			op = OP_INSERT;
		else
			op = OP_SEARCH;
		if (op == OP_SEARCH && held_count > 0 && $urandom_range(99) < 70)
			k = held_keys[$urandom_range(held_count - 1, 0)];
		else if ($urandom_range(1) == 0)
			k = key_t'(int'($urandom_range(7)) - 4);
		else
			k = key_t'($urandom_range(255));
		send_beat(op, k, 1'($urandom_range(1)), 1'b0, '0);
	endtask

	// hold off until every response is back
	task automatic drain_wait();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

	always @(posedge clk) begin
		rsp_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response beat with no expectation waiting");
				fail_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
					fail_count++;
				end
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
					fail_count++;
				end
				if (rsp_ch.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, rsp_ch.position);
					fail_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_ch.entry_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sorted_char_list_insert_search_core verification failed");
			$finish;
		end
	end

	initial begin
		int row;
		int n;
		int phase;
		req_ch.valid     = 1'b0;
		req_ch.opcode    = OP_INSERT;
		req_ch.key_value = '0;
		req_ch.from_end  = 1'b0;
		rsp_ch.ready     = 1'b0;
		held_count       = 0;
		fail_count       = 0;
		quiet_cycles     = 0;
		src_idle_pct     = 7;
		snk_stall_pct    = 56;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < $size(dir_rows); row++)
			send_beat(dir_rows[row].op, key_t'(dir_rows[row].key), dir_rows[row].fe,
				dir_rows[row].fixed, dir_rows[row].want);

		for (phase = 0; phase < 3; phase++) begin
			drain_wait();
			src_idle_pct  = (phase == 0) ? 7 : (phase == 1) ? 56 : 0;
			snk_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 7 : 0;
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == RANDOM_PER_PHASE / 2)
					drain_wait();
				send_random();
			end
		end

		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("sorted_char_list_insert_search_core verification clean");
		else
			$display("sorted_char_list_insert_search_core verification failed");
		$finish;
	end
endmodule
